[rtl/mre_pkg.sv]
// Package for the multimodal rotary embedding block: payload types, build-time
// inverse-frequency and arctangent tables, pipeline lengths. No dependencies.
package mre_pkg;

    localparam int VEC_DIM       = 128;
    localparam int PAIR_SPAN     = VEC_DIM / 2;
    localparam int POS_BITS      = 16;
    localparam longint THETA     = 1000000;
    localparam int CORDIC_STAGES = 16;
    localparam int ROM_DEPTH     = 64;
    localparam int ATAN_SLOTS    = 32;
    localparam int LANE_LAT      = CORDIC_STAGES + 3;
    localparam int PIPE_LAT      = LANE_LAT + 2;

    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [63:0] PI_OVER4_Q60 = 64'h0C90FDAA22168C23;

    localparam logic [1:0] CFG_TEMPORAL = 2'd0;
    localparam logic [1:0] CFG_HEIGHT   = 2'd1;

    typedef struct packed {
        logic signed [15:0] x_low;
        logic signed [15:0] x_high;
        logic [15:0]        pos_temporal;
        logic [15:0]        pos_height;
        logic [15:0]        pos_width;
        logic [5:0]         pair_index;
    } t_in;

    typedef struct packed {
        logic signed [15:0] y_low;
        logic signed [15:0] y_high;
    } t_out;

    typedef struct packed {
        logic signed [15:0] cos_v;
        logic signed [15:0] sin_v;
    } t_trig;

    typedef logic [31:0] t_rom [ROM_DEPTH];
    typedef logic [31:0] t_atan [ATAN_SLOTS];

    function automatic logic [63:0] isqrt(input logic [63:0] n_in);
        logic [63:0] n, res, bit_v;
        n = n_in;
        res = '0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (n >= res + bit_v) begin
                n = n - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic t_rom build_rom();
        t_rom rom;
        logic [63:0] roots [0:32];
        logic [63:0] t, y, frac, logq, e, k, f, v, tv;
        int n;
        t = 64'(THETA);
        n = 0;
        for (int b = 0; b < 64; b++) begin
            if (t > 1) begin
                t = t >> 1;
                n++;
            end
        end
        y = (n <= 31) ? (64'(THETA) << 31) >> n : 64'd0;
        frac = '0;
        for (int b = 1; b <= 32; b++) begin
            y = (y * y) >> 31;
            if (y >= 64'h1_0000_0000) begin
                y = y >> 1;
                frac = frac | (64'd1 << (32 - b));
            end
        end
        logq = (64'(n) << 32) | frac;
        roots[0] = '0;
        roots[1] = isqrt(64'h8000_0000_0000_0000);
        for (int j = 2; j <= 32; j++) roots[j] = isqrt(roots[j-1] << 32);
        for (int i = 0; i < ROM_DEPTH; i++) begin
            e = (i < PAIR_SPAN) ? (logq * 64'(i)) / PAIR_SPAN : 64'd0;
            k = e >> 32;
            f = e & 64'hFFFF_FFFF;
            v = 64'h1_0000_0000;
            for (int j = 1; j <= 32; j++)
                if (f[32-j]) v = (v * roots[j]) >> 32;
            tv = (v * INV_TWO_PI_Q32) >> 32;
            rom[i] = (k >= 32) ? 32'd0 : 32'(tv >> k);
        end
        return rom;
    endfunction

    function automatic t_atan build_atan();
        t_atan tab;
        logic [63:0] acc, term;
        tab[0] = 32'((PI_OVER4_Q60 + (64'd1 << 29)) >> 30);
        for (int i = 1; i < ATAN_SLOTS; i++) begin
            acc = '0;
            for (int m = 0; m < 31; m++) begin
                if (i * (2 * m + 1) <= 60) begin
                    term = udiv(64'd1 << (60 - i * (2 * m + 1)), 64'(2 * m + 1));
                    if (m % 2 == 1) acc = acc - term;
                    else acc = acc + term;
                end
            end
            tab[i] = 32'((acc + (64'd1 << 29)) >> 30);
        end
        return tab;
    endfunction

    localparam t_rom  FREQ_TURNS = build_rom();
    localparam t_atan ATAN_Q30   = build_atan();

endpackage

[rtl/mre_lane.sv]
// One angle lane: phase from position and inverse frequency, CORDIC pipeline,
// quadrant fold and rounding to Q1.15. Depends on mre_pkg.
module mre_lane (
    input  logic              i_clk,
    input  logic [15:0]       i_pos,
    input  logic [31:0]       i_rom,
    output mre_pkg::t_trig    o_trig
);
    import mre_pkg::*;

    logic [31:0]        r_phase;
    logic [1:0]         r_quad [0:CORDIC_STAGES];
    logic signed [33:0] r_x [0:CORDIC_STAGES];
    logic signed [33:0] r_y [0:CORDIC_STAGES];
    logic signed [32:0] r_z [0:CORDIC_STAGES];
    logic [61:0]        w_zprod;
    logic signed [33:0] w_cx, w_sy;
    logic signed [18:0] w_cr, w_sr;
    t_trig              r_trig;

    assign w_zprod = 62'(r_phase[29:0]) * 62'(TWO_PI_Q29);

    always_ff @(posedge i_clk) begin
        r_phase  <= 32'(48'(i_pos) * 48'(i_rom));
        r_quad[0] <= r_phase[31:30];
        r_x[0]    <= CORDIC_GAIN_Q30;
        r_y[0]    <= '0;
        r_z[0]    <= 33'(w_zprod >> 31);
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_quad[g+1] <= r_quad[g];
            if (!r_z[g][32]) begin
                r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] - 33'(ATAN_Q30[g]);
            end else begin
                r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] + 33'(ATAN_Q30[g]);
            end
        end
    end

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767) return 16'sd32767;
        if (v < -19'sd32768) return -16'sd32768;
        return 16'(v);
    endfunction

    always_comb begin
        case (r_quad[CORDIC_STAGES])
            2'd0: begin
                w_cx = r_x[CORDIC_STAGES];
                w_sy = r_y[CORDIC_STAGES];
            end
            2'd1: begin
                w_cx = -r_y[CORDIC_STAGES];
                w_sy = r_x[CORDIC_STAGES];
            end
            2'd2: begin
                w_cx = -r_x[CORDIC_STAGES];
                w_sy = -r_y[CORDIC_STAGES];
            end
            default: begin
                w_cx = r_y[CORDIC_STAGES];
                w_sy = -r_x[CORDIC_STAGES];
            end
        endcase
        w_cr = 19'((w_cx + 34'sd16384) >>> 15);
        w_sr = 19'((w_sy + 34'sd16384) >>> 15);
    end

    always_ff @(posedge i_clk) begin
        r_trig.cos_v <= sat16(w_cr);
        r_trig.sin_v <= sat16(w_sr);
    end

    assign o_trig = r_trig;
endmodule

[rtl/mre_merge.sv]
// Merge stage: rotates the element pair with both lanes' cos and sin, rounds
// to Q7.8 and saturates. Depends on mre_pkg.
module mre_merge (
    input  logic               i_clk,
    input  logic signed [15:0] i_xl,
    input  logic signed [15:0] i_xh,
    input  mre_pkg::t_trig     i_low,
    input  mre_pkg::t_trig     i_high,
    output mre_pkg::t_out      o_out
);
    import mre_pkg::*;

    logic signed [31:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [33:0] w_sl, w_sh;
    logic signed [18:0] w_rl, w_rh;
    t_out               r_out;

    function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
        if (v > 19'sd32767) return 16'sd32767;
        if (v < -19'sd32768) return -16'sd32768;
        return 16'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        r_p0 <= i_xl * i_low.cos_v;
        r_p1 <= i_xh * i_low.sin_v;
        r_p2 <= i_xh * i_high.cos_v;
        r_p3 <= i_xl * i_high.sin_v;
    end

    always_comb begin
        w_sl = 34'(r_p0) - 34'(r_p1) + 34'sd16384;
        w_sh = 34'(r_p2) + 34'(r_p3) + 34'sd16384;
        w_rl = 19'(w_sl >>> 15);
        w_rh = 19'(w_sh >>> 15);
    end

    always_ff @(posedge i_clk) begin
        r_out.y_low  <= sat16(w_rl);
        r_out.y_high <= sat16(w_rh);
    end

    assign o_out = r_out;
endmodule

[rtl/mrope_rotary_embedding.sv]
// Multimodal rotary position embedding, top level. Depends on mre_pkg,
// mre_lane and mre_merge.
//
// Usage: present one element pair with its three positions and pair index on
// i_in and raise start; busy stays low, so a beat is taken every cycle.
// Each beat yields one result on o_out, marked by o_valid for one cycle.
// Throughput is one pair per clock: two angle lanes (one per element) each
// run a fully pipelined CORDIC of CORDIC_STAGES registered iterations, and
// a merge stage applies the rotation.
// The section sizes are written through the cfg channel (index 0 temporal,
// index 1 height), always ready; write them only while the pipe is empty.
// Reset (synchronous, active low) empties the pipe and loads 16 and 24.
// The receiver cannot stall; results must be taken as they appear.
module mrope_rotary_embedding (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  mre_pkg::t_in    i_in,
    output logic            o_valid,
    output mre_pkg::t_out   o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [6:0]      i_cfg_data
);
    import mre_pkg::*;

    typedef struct packed {
        logic               byp;
        logic signed [15:0] xl;
        logic signed [15:0] xh;
    } t_pass;

    logic [6:0]  r_tp, r_hp;
    logic        r_dv [0:PIPE_LAT];
    t_pass       r_dx [0:PIPE_LAT];
    logic [31:0] r_rom;
    logic [15:0] r_posl, r_posh;
    logic [8:0]  w_t2, w_h2, w_dl, w_dh;
    logic [15:0] w_posl, w_posh;
    t_trig       w_tl, w_th;
    t_out        w_rot;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tp <= 7'd16;
            r_hp <= 7'd24;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TEMPORAL: r_tp <= i_cfg_data;
                CFG_HEIGHT:   r_hp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_t2 = {1'b0, r_tp, 1'b0};
        w_h2 = w_t2 + {1'b0, r_hp, 1'b0};
        w_dl = 9'(i_in.pair_index);
        w_dh = 9'(i_in.pair_index) + 9'(PAIR_SPAN);
        if (w_dl < w_t2)      w_posl = i_in.pos_temporal;
        else if (w_dl < w_h2) w_posl = i_in.pos_height;
        else                  w_posl = i_in.pos_width;
        if (w_dh < w_t2)      w_posh = i_in.pos_temporal;
        else if (w_dh < w_h2) w_posh = i_in.pos_height;
        else                  w_posh = i_in.pos_width;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= PIPE_LAT; k++) r_dv[k] <= 1'b0;
        end else begin
            r_dv[0] <= start;
            for (int k = 1; k <= PIPE_LAT; k++) r_dv[k] <= r_dv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx[0].byp <= (w_dl >= 9'(PAIR_SPAN));
        r_dx[0].xl  <= i_in.x_low;
        r_dx[0].xh  <= i_in.x_high;
        for (int k = 1; k <= PIPE_LAT; k++) r_dx[k] <= r_dx[k-1];
        r_rom  <= FREQ_TURNS[i_in.pair_index];
        r_posl <= w_posl & 16'((17'd1 << POS_BITS) - 17'd1);
        r_posh <= w_posh & 16'((17'd1 << POS_BITS) - 17'd1);
    end

    mre_lane u_lane_low (
        .i_clk  (i_clk),
        .i_pos  (r_posl),
        .i_rom  (r_rom),
        .o_trig (w_tl)
    );

    mre_lane u_lane_high (
        .i_clk  (i_clk),
        .i_pos  (r_posh),
        .i_rom  (r_rom),
        .o_trig (w_th)
    );

    mre_merge u_merge (
        .i_clk  (i_clk),
        .i_xl   (r_dx[LANE_LAT].xl),
        .i_xh   (r_dx[LANE_LAT].xh),
        .i_low  (w_tl),
        .i_high (w_th),
        .o_out  (w_rot)
    );

    assign o_valid = r_dv[PIPE_LAT];
    always_comb begin
        if (r_dx[PIPE_LAT].byp) begin
            o_out.y_low  = r_dx[PIPE_LAT].xl;
            o_out.y_high = r_dx[PIPE_LAT].xh;
        end else begin
            o_out = w_rot;
        end
    end
endmodule
